@@ rtl/awt_pkg.sv @@
// Shared types, codes and reset values for the ack window tracker.
`timescale 1ns / 1ps
package awt_pkg;

	localparam int SEQ_W      = 10;
	localparam int STAT_W     = 3;
	localparam int MISS_W     = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int WIN_W      = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_START_SEQ   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MISS_LIMIT  = 2'd2;

	// status codes
	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_DUP_PLAIN = 3'd1;
	localparam logic [STAT_W-1:0] ST_DUP_UPPER = 3'd2;
	localparam logic [STAT_W-1:0] ST_DUP_LOWER = 3'd3;
	localparam logic [STAT_W-1:0] ST_OOW_WRAP  = 3'd4;
	localparam logic [STAT_W-1:0] ST_OOW_PLAIN = 3'd5;
	localparam logic [STAT_W-1:0] ST_LOST      = 3'd6;

	// register reset values
	localparam logic [SEQ_W-1:0]  RST_START_SEQ   = 10'd0;
	localparam logic [SEQ_W-1:0]  RST_WINDOW_SIZE = 10'd64;
	localparam logic [MISS_W-1:0] RST_MISS_LIMIT  = 16'd8;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SEQ_W-1:0]  lost_seq;
		logic [SEQ_W-1:0]  head_seq;
	} res_t;

	// window bounds from the reload unit, widest sequence space
	typedef struct packed {
		logic             done;
		logic [WIN_W-1:0] head;
		logic [WIN_W-1:0] tail;
	} win_t;

endpackage

@@ rtl/awt_ifs.sv @@
// Handshake channel interfaces: ack input, result output, register writes.
`timescale 1ns / 1ps
interface awt_ack_if import awt_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SEQ_W-1:0] ack_seq;

	modport source (output valid, output ack_seq, input ready);
	modport sink (input valid, input ack_seq, output ready);
endinterface

interface awt_res_if import awt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [SEQ_W-1:0]  lost_seq;
	logic [SEQ_W-1:0]  head_seq;

	modport source (output valid, output status, output lost_seq, output head_seq, input ready);
	modport sink (input valid, input status, input lost_seq, input head_seq, output ready);
endinterface

interface awt_cfg_if import awt_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/ack_window_tracker_top.sv @@
// Top level of the ack window tracker: sequencer, window reload unit and bitmap RAM.
`timescale 1ns / 1ps
// Selective-ack receiver over a sliding window in a modular sequence space.
// Channels (valid/ready, a word moves when both are high):
//   ack - one ack number per word; res - status, lost head and window head;
//   cfg - register writes: 0 start_seq, 1 window_size, 2 miss_limit.
//   A start_seq or window_size write reloads the window bounds; the bitmap
//   and the miss count are kept.
// Steps from accept to result word on res: a duplicate or out-of-window
// ack goes from the bitmap read straight to the result; otherwise its bit
// is set and the head is checked, and if the head is acked the window
// slides. The slide walks the bitmap one number per cycle through the RAM
// read port; one ack is in work at a time, and the next is taken only
// once its result is registered.
// Reset: a clearing pass writes every bitmap entry, then a window reload
// that subtracts the sequence space from start and size until both lie
// within it. No ack is taken meanwhile; cfg is open during the clearing
// pass. A write of a window register takes the same reload.
// Receiver stall: a finished word waits in the output register; the next
// ack may be taken and worked on, and holds in its last step until the
// output register is drained.
module ack_window_tracker_top import awt_pkg::*; #(
	parameter int MAX_SEQ = 1023
) (
	input  logic clk,
	input  logic arst_n,
	awt_ack_if.sink   ack,
	awt_res_if.source res,
	awt_cfg_if.sink   cfg
);

	localparam int SW = $clog2(MAX_SEQ + 1);

	res_t             res_word;
	win_t             win;
	logic             load_start;
	logic [SEQ_W-1:0] load_start_seq;
	logic [SEQ_W-1:0] load_window_size;
	logic             mem_we;
	logic [SW-1:0]    mem_waddr;
	logic             mem_wdata;
	logic [SW-1:0]    mem_raddr;
	logic             mem_rdata;

	// sequencer: classification, read-modify-write of the bitmap, slide
	awt_ctrl #(
		.MAX_SEQ (MAX_SEQ),
		.SW      (SW)
	) u_ctrl (
		.clk              (clk),
		.arst_n           (arst_n),
		.ack_valid        (ack.valid),
		.ack_ready        (ack.ready),
		.ack_seq          (ack.ack_seq),
		.cfg_valid        (cfg.valid),
		.cfg_ready        (cfg.ready),
		.cfg_index        (cfg.index),
		.cfg_data         (cfg.data),
		.res_valid        (res.valid),
		.res_ready        (res.ready),
		.res_word         (res_word),
		.load_start       (load_start),
		.load_start_seq   (load_start_seq),
		.load_window_size (load_window_size),
		.win              (win),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_raddr        (mem_raddr),
		.mem_rdata        (mem_rdata)
	);

	// window bounds from the registers, reduced into the sequence space
	awt_wload #(
		.MAX_SEQ (MAX_SEQ)
	) u_wload (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (load_start),
		.start_seq   (load_start_seq),
		.window_size (load_window_size),
		.win         (win)
	);

	// one acked bit per sequence number
	awt_map_ram #(
		.DEPTH (MAX_SEQ + 1),
		.AW    (SW)
	) u_map (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	assign res.status   = res_word.status;
	assign res.lost_seq = res_word.lost_seq;
	assign res.head_seq = res_word.head_seq;

endmodule

@@ rtl/awt_map_ram.sv @@
// Acked bitmap: one write port, one read port, registered read data.
`timescale 1ns / 1ps
module awt_map_ram #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic          wdata,
	input  logic [AW-1:0] raddr,
	output logic          rdata_q
);

	logic mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

endmodule

@@ rtl/awt_wload.sv @@
// Window reload: reduces start and size into the sequence space, forms head and tail.
`timescale 1ns / 1ps
module awt_wload import awt_pkg::*; #(
	parameter int MAX_SEQ = 1023
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [SEQ_W-1:0] start_seq,
	input  logic [SEQ_W-1:0] window_size,
	output win_t             win
);

	localparam int SPACE = MAX_SEQ + 1;
	localparam int SW    = $clog2(SPACE);
	localparam int XW    = (SW + 1 > SEQ_W + 1) ? SW + 1 : SEQ_W + 1;

	logic          busy_q;
	logic [XW-1:0] s_q;
	logic [XW-1:0] z_q;
	logic          s_big;
	logic          z_big;
	logic [XW-1:0] sum;
	logic [XW-1:0] tail;

	assign s_big = (s_q >= XW'(SPACE));
	assign z_big = (z_q >= XW'(SPACE));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (win.done) begin
			busy_q <= 1'b0;
		end
	end

	// one subtraction of the space per cycle until both are reduced
	always_ff @(posedge clk) begin
		if (start) begin
			s_q <= XW'(start_seq);
			z_q <= XW'(window_size);
		end else begin
			if (s_big) begin
				s_q <= s_q - XW'(SPACE);
			end
			if (z_big) begin
				z_q <= z_q - XW'(SPACE);
			end
		end
	end

	always_comb begin
		sum  = s_q + z_q;
		tail = sum - 1'b1;
		if (z_q == '0) begin
			// empty size covers the whole space
			tail = (s_q == '0) ? XW'(MAX_SEQ) : s_q - 1'b1;
		end else if (tail >= XW'(SPACE)) begin
			tail = tail - XW'(SPACE);
		end
	end

	assign win.done = busy_q && !s_big && !z_big;
	assign win.head = WIN_W'(s_q);
	assign win.tail = WIN_W'(tail);

endmodule

@@ rtl/awt_ctrl.sv @@
// Sequencer: ack classification, bitmap read-modify-write, slide, registers, result word.
`timescale 1ns / 1ps
module awt_ctrl import awt_pkg::*; #(
	parameter int MAX_SEQ = 1023,
	parameter int SW      = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  ack_valid,
	output logic                  ack_ready,
	input  logic [SEQ_W-1:0]      ack_seq,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  res_valid,
	input  logic                  res_ready,
	output res_t                  res_word,
	output logic                  load_start,
	output logic [SEQ_W-1:0]      load_start_seq,
	output logic [SEQ_W-1:0]      load_window_size,
	input  win_t                  win,
	output logic                  mem_we,
	output logic [SW-1:0]         mem_waddr,
	output logic                  mem_wdata,
	output logic [SW-1:0]         mem_raddr,
	input  logic                  mem_rdata
);

	localparam int SPACE = MAX_SEQ + 1;
	localparam int XW    = (SW + 1 > SEQ_W + 1) ? SW + 1 : SEQ_W + 1;

	typedef enum logic [6:0] {
		S_CLEAR = 7'b0000001,
		S_LOAD  = 7'b0000010,
		S_IDLE  = 7'b0000100,
		S_POS   = 7'b0001000,
		S_HEAD  = 7'b0010000,
		S_SLIDE = 7'b0100000,
		S_EMIT  = 7'b1000000
	} state_t;

	function automatic logic [SW-1:0] seq_inc(input logic [SW-1:0] v);
		return (v == SW'(MAX_SEQ)) ? '0 : v + 1'b1;
	endfunction

	state_t              state_q;
	logic [SW-1:0]       clr_q;
	logic [SEQ_W-1:0]    start_seq_q;
	logic [SEQ_W-1:0]    window_size_q;
	logic [MISS_W-1:0]   miss_limit_q;
	logic [MISS_W-1:0]   miss_q;
	logic [SW-1:0]       head_q;
	logic [SW-1:0]       tail_q;
	logic [XW-1:0]       steps_q;
	logic                fwd_q;
	logic                res_valid_q;
	logic [SEQ_W-1:0]    pos_q;
	logic [STAT_W-1:0]   cls_q;
	logic                inwin_q;
	logic [STAT_W-1:0]   pend_status_q;
	logic [SW-1:0]       pend_lost_q;
	res_t                res_word_q;

	logic                ack_fire;
	logic                cfg_fire;
	logic                cfg_win;
	logic [XW-1:0]       pos_x;
	logic [XW-1:0]       head_x;
	logic [XW-1:0]       tail_x;
	logic                in_plain;
	logic                wrapped;
	logic                upper;
	logic                lower;
	logic [STAT_W-1:0]   cls;
	logic                inwin;
	logic                head_bit;
	logic [SW-1:0]       head_nx;
	logic [SW-1:0]       tail_nx;
	logic [MISS_W-1:0]   miss_inc;
	logic                slide_more;
	logic                out_free;

	assign ack_ready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready = (state_q == S_IDLE) || (state_q == S_CLEAR);
	assign ack_fire  = ack_valid && ack_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign cfg_win   = cfg_fire && ((cfg_index == CFG_START_SEQ) || (cfg_index == CFG_WINDOW_SIZE));

	// window check of the incoming ack
	assign pos_x    = XW'(ack_seq);
	assign head_x   = XW'(head_q);
	assign tail_x   = XW'(tail_q);
	assign in_plain = (head_x <= pos_x) && (pos_x <= tail_x);
	assign wrapped  = (tail_x < head_x);
	assign upper    = (head_x <= pos_x) && (pos_x <= XW'(MAX_SEQ));
	assign lower    = (pos_x <= tail_x);
	assign inwin    = in_plain || (wrapped && (upper || lower));

	always_comb begin
		if (in_plain) begin
			cls = ST_DUP_PLAIN;
		end else if (!wrapped) begin
			cls = ST_OOW_PLAIN;
		end else if (upper) begin
			cls = ST_DUP_UPPER;
		end else if (lower) begin
			cls = ST_DUP_LOWER;
		end else begin
			cls = ST_OOW_WRAP;
		end
	end

	// head bit: the ack just written may be the head itself
	assign head_bit   = mem_rdata || (XW'(pos_q) == head_x);
	assign head_nx    = seq_inc(head_q);
	assign tail_nx    = seq_inc(tail_q);
	assign miss_inc   = (miss_q == '1) ? miss_q : miss_q + 1'b1;
	// a freshly cleared tail that is also the new head reads as unacked
	assign slide_more = mem_rdata && !fwd_q && (steps_q < XW'(SPACE));
	assign out_free   = !res_valid_q || res_ready;

	assign load_start       = ((state_q == S_CLEAR) && (clr_q == SW'(MAX_SEQ))) ||
	                          ((state_q == S_IDLE) && cfg_win);
	assign load_start_seq   = (cfg_fire && (cfg_index == CFG_START_SEQ)) ?
	                          cfg_data[SEQ_W-1:0] : start_seq_q;
	assign load_window_size = (cfg_fire && (cfg_index == CFG_WINDOW_SIZE)) ?
	                          cfg_data[SEQ_W-1:0] : window_size_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = tail_nx;
		mem_wdata = 1'b0;
		mem_raddr = SW'(ack_seq);
		case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			S_POS: begin
				mem_raddr = head_q;
				if (inwin_q && !mem_rdata) begin
					mem_we    = 1'b1;
					mem_waddr = SW'(pos_q);
					mem_wdata = 1'b1;
				end
			end
			S_HEAD: begin
				mem_raddr = head_nx;
				mem_we    = head_bit;
			end
			S_SLIDE: begin
				mem_raddr = head_nx;
				mem_we    = slide_more;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			start_seq_q   <= RST_START_SEQ;
			window_size_q <= RST_WINDOW_SIZE;
			miss_limit_q  <= RST_MISS_LIMIT;
			miss_q        <= '0;
			head_q        <= '0;
			tail_q        <= '0;
			steps_q       <= '0;
			fwd_q         <= 1'b0;
			res_valid_q   <= 1'b0;
		end else begin
			start_seq_q   <= load_start_seq;
			window_size_q <= load_window_size;
			if (cfg_fire && (cfg_index == CFG_MISS_LIMIT)) begin
				miss_limit_q <= cfg_data[MISS_W-1:0];
			end
			if ((state_q == S_EMIT) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == SW'(MAX_SEQ)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					if (win.done) begin
						head_q  <= SW'(win.head);
						tail_q  <= SW'(win.tail);
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cfg_win) begin
						state_q <= S_LOAD;
					end else if (ack_fire) begin
						state_q <= S_POS;
					end
				end
				S_POS: begin
					state_q <= (!inwin_q || mem_rdata) ? S_EMIT : S_HEAD;
				end
				S_HEAD: begin
					if (!head_bit) begin
						miss_q  <= miss_inc;
						state_q <= S_EMIT;
					end else begin
						miss_q  <= '0;
						head_q  <= head_nx;
						tail_q  <= tail_nx;
						fwd_q   <= (tail_nx == head_nx);
						steps_q <= XW'(1);
						state_q <= S_SLIDE;
					end
				end
				S_SLIDE: begin
					if (slide_more) begin
						head_q  <= head_nx;
						tail_q  <= tail_nx;
						fwd_q   <= (tail_nx == head_nx);
						steps_q <= steps_q + 1'b1;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ack_fire) begin
			pos_q   <= ack_seq;
			cls_q   <= cls;
			inwin_q <= inwin;
		end
		case (state_q)
			S_POS: begin
				pend_status_q <= cls_q;
				pend_lost_q   <= '0;
			end
			S_HEAD: begin
				if (!head_bit && (miss_inc >= miss_limit_q)) begin
					pend_status_q <= ST_LOST;
					pend_lost_q   <= head_q;
				end else begin
					pend_status_q <= ST_OK;
					pend_lost_q   <= '0;
				end
			end
			default: begin
				pend_status_q <= pend_status_q;
				pend_lost_q   <= pend_lost_q;
			end
		endcase
		if ((state_q == S_EMIT) && out_free) begin
			res_word_q.status   <= pend_status_q;
			res_word_q.lost_seq <= SEQ_W'(pend_lost_q);
			res_word_q.head_seq <= SEQ_W'(head_q);
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

endmodule
